FILE: sv/cfc_pkg.sv
// Shared types, constants and helper functions for the chorus and flanger chain.
// Used by cfc_ctrl, cfc_dp and the top level; depends on nothing else.
package cfc_pkg;

	// Delay line and sine table geometry.
	localparam int CL_DEPTH = 4096;
	localparam int CL_AW = $clog2(CL_DEPTH);
	localparam int FL_DEPTH = 2048;
	localparam int FL_AW = $clog2(FL_DEPTH);
	localparam int SINE_DEPTH = 1024;
	localparam int SINE_AW = $clog2(SINE_DEPTH);
	localparam logic signed [22:0] FLANGER_BASE_Q8 = 23'sd33869;

	// Register indexes on the configuration port.
	localparam logic [2:0] REG_C_BASE = 3'd0;
	localparam logic [2:0] REG_C_DEPTH = 3'd1;
	localparam logic [2:0] REG_C_STEP = 3'd2;
	localparam logic [2:0] REG_C_MIX = 3'd3;
	localparam logic [2:0] REG_F_DEPTH = 3'd4;
	localparam logic [2:0] REG_F_STEP = 3'd5;
	localparam logic [2:0] REG_F_FB = 3'd6;
	localparam logic [2:0] REG_F_MIX = 3'd7;

	// Register reset values.
	localparam logic [19:0] RST_C_BASE = 20'd225792;
	localparam logic [19:0] RST_C_DEPTH = 20'd0;
	localparam logic [30:0] RST_C_STEP = 31'd9739;
	localparam logic [15:0] RST_C_MIX = 16'd19661;
	localparam logic [18:0] RST_F_DEPTH = 19'd56448;
	localparam logic [30:0] RST_F_STEP = 31'd29217;
	localparam logic [15:0] RST_F_FB = 16'd29491;
	localparam logic [15:0] RST_F_MIX = 16'd9830;

	// Sine polynomial coefficients in Q30.
	localparam longint Q30_ONE = 64'sd1073741824;
	localparam longint SIN_A1 = 64'sd1686629713;
	localparam longint SIN_A3 = -64'sd693598669;
	localparam longint SIN_A5 = 64'sd85569306;
	localparam longint SIN_A7 = -64'sd5026994;
	localparam longint SIN_A9 = 64'sd172273;

	// Datapath operations issued by the controller.
	typedef enum logic [4:0] {
		OP_IDLE, OP_CLEAR, OP_PHASE, OP_SINE, OP_MDEP, OP_DELAY, OP_RD1, OP_RD2,
		OP_DIFF, OP_MFR, OP_INTERP, OP_C_MIXA, OP_C_MIXB, OP_C_MIXC,
		OP_F_FB, OP_F_FIN, OP_F_MIXB, OP_F_OUT
	} op_t;

	typedef struct packed {
		op_t              op;
		logic             fx;       // 0 chorus, 1 flanger
		logic             load;     // capture a new dry sample
		logic [CL_AW-1:0] clr_addr;
	} cmd_t;

	typedef struct packed {
		logic out_full;
	} sts_t;

	typedef logic signed [15:0] sine_tab_t [SINE_DEPTH];

	// Quarter-wave folded odd polynomial, rounded to Q1.15.
	function automatic logic signed [15:0] sine_of_phase(input logic [31:0] ph);
		longint x, x2, t, y;
		x = longint'({34'd0, ph[29:0]});
		if (ph[30]) x = Q30_ONE - x;
		x2 = (x * x) / Q30_ONE;
		t = SIN_A9;
		t = SIN_A7 + (t * x2) / Q30_ONE;
		t = SIN_A5 + (t * x2) / Q30_ONE;
		t = SIN_A3 + (t * x2) / Q30_ONE;
		t = SIN_A1 + (t * x2) / Q30_ONE;
		y = (t * x) / Q30_ONE;
		if (y < 0) y = 0;
		y = (y + 64'sd16384) >>> 15;
		if (y > 64'sd32767) y = 64'sd32767;
		if (ph[31]) y = -y;
		return y[15:0];
	endfunction

	function automatic sine_tab_t make_sine_tab();
		sine_tab_t tab;
		for (int i = 0; i < SINE_DEPTH; i++) begin
			tab[i] = sine_of_phase(32'(longint'(i) << (32 - SINE_AW)));
		end
		return tab;
	endfunction

	localparam sine_tab_t SINE_TAB = make_sine_tab();

	// Saturate a wide signed value to 24 bits.
	function automatic logic signed [23:0] sat24(input logic signed [47:0] v);
		if (v > 48'sd8388607) return 24'sh7FFFFF;
		if (v < -48'sd8388608) return 24'sh800000;
		return v[23:0];
	endfunction

	// Gains above unity are held at unity.
	function automatic logic [16:0] gain17(input logic [15:0] g);
		return (g > 16'd32768) ? 17'd32768 : {1'b0, g};
	endfunction

endpackage

FILE: sv/cfc_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies; used for both delay lines.
module cfc_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 4096,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write, and read the old contents of the same address.
	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rdata <= mem[addr];
	end

endmodule

FILE: sv/cfc_ctrl.sv
// Sequencer for the chorus and flanger chain: clears the lines after reset,
// then steps each sample through both effects. Depends on cfc_pkg.
module cfc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  cfc_pkg::sts_t sts,
	output cfc_pkg::cmd_t cmd
);

	typedef enum logic [4:0] {
		ST_CLEAR, ST_IDLE, ST_PHASE, ST_SINE, ST_MDEP, ST_DELAY, ST_RD1, ST_RD2,
		ST_DIFF, ST_MFR, ST_INTERP, ST_C_MIXA, ST_C_MIXB, ST_C_MIXC,
		ST_F_FB, ST_F_FIN, ST_F_MIXB, ST_F_OUT
	} state_t;

	state_t                    state_q;
	logic                      fx_q;
	logic [cfc_pkg::CL_AW-1:0] clr_q;

	assign in_ready = (state_q == ST_IDLE);

	// Decode the state into a datapath command.
	always_comb begin
		cmd.fx = fx_q;
		cmd.clr_addr = clr_q;
		cmd.load = in_valid && in_ready;
		case (state_q)
			ST_CLEAR:  cmd.op = cfc_pkg::OP_CLEAR;
			ST_IDLE:   cmd.op = cfc_pkg::OP_IDLE;
			ST_PHASE:  cmd.op = cfc_pkg::OP_PHASE;
			ST_SINE:   cmd.op = cfc_pkg::OP_SINE;
			ST_MDEP:   cmd.op = cfc_pkg::OP_MDEP;
			ST_DELAY:  cmd.op = cfc_pkg::OP_DELAY;
			ST_RD1:    cmd.op = cfc_pkg::OP_RD1;
			ST_RD2:    cmd.op = cfc_pkg::OP_RD2;
			ST_DIFF:   cmd.op = cfc_pkg::OP_DIFF;
			ST_MFR:    cmd.op = cfc_pkg::OP_MFR;
			ST_INTERP: cmd.op = cfc_pkg::OP_INTERP;
			ST_C_MIXA: cmd.op = cfc_pkg::OP_C_MIXA;
			ST_C_MIXB: cmd.op = cfc_pkg::OP_C_MIXB;
			ST_C_MIXC: cmd.op = cfc_pkg::OP_C_MIXC;
			ST_F_FB:   cmd.op = cfc_pkg::OP_F_FB;
			ST_F_FIN:  cmd.op = cfc_pkg::OP_F_FIN;
			ST_F_MIXB: cmd.op = cfc_pkg::OP_F_MIXB;
			ST_F_OUT:  cmd.op = cfc_pkg::OP_F_OUT;
			default:   cmd.op = cfc_pkg::OP_IDLE;
		endcase
	end

	// State register, effect select and clear address.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			fx_q <= 1'b0;
			clr_q <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == {cfc_pkg::CL_AW{1'b1}}) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					fx_q <= 1'b0;
					if (in_valid) state_q <= ST_PHASE;
				end
				ST_PHASE:  state_q <= ST_SINE;
				ST_SINE:   state_q <= ST_MDEP;
				ST_MDEP:   state_q <= ST_DELAY;
				ST_DELAY:  state_q <= ST_RD1;
				ST_RD1:    state_q <= ST_RD2;
				ST_RD2:    state_q <= ST_DIFF;
				ST_DIFF:   state_q <= ST_MFR;
				ST_MFR:    state_q <= ST_INTERP;
				ST_INTERP: state_q <= fx_q ? ST_F_FB : ST_C_MIXA;
				ST_C_MIXA: state_q <= ST_C_MIXB;
				ST_C_MIXB: state_q <= ST_C_MIXC;
				ST_C_MIXC: begin
					fx_q <= 1'b1;
					state_q <= ST_PHASE;
				end
				ST_F_FB:   state_q <= ST_F_FIN;
				ST_F_FIN:  state_q <= ST_F_MIXB;
				ST_F_MIXB: state_q <= ST_F_OUT;
				ST_F_OUT: begin
					if (!sts.out_full) state_q <= ST_IDLE;
				end
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

	// A result only leaves the last state once the output register is free.
	ap_out_wait: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_F_OUT && sts.out_full |=> state_q == ST_F_OUT)
		else $error("left output state while output register was full");
	// The chorus pass is always followed by the flanger pass.
	ap_fx_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_C_MIXC |=> state_q == ST_PHASE && fx_q)
		else $error("flanger pass did not follow chorus pass");
	// No request is taken during the clearing pass.
	ap_clear_block: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> !in_ready)
		else $error("input taken while clearing");

endmodule

FILE: sv/cfc_dp.sv
// Datapath of the chorus and flanger chain: LFOs, sine table, shared multiplier,
// both delay lines and the output register. Depends on cfc_pkg and cfc_ram.
module cfc_dp (
	input  logic          clk,
	input  logic          arst_n,
	input  cfc_pkg::cmd_t cmd,
	output cfc_pkg::sts_t sts,
	input  logic [23:0]   dry_in,
	input  logic          cfg_we,
	input  logic [2:0]    cfg_index,
	input  logic [31:0]   cfg_data,
	output logic [23:0]   out_sample,
	output logic          out_valid,
	input  logic          out_ready
);

	// Configuration registers.
	logic [19:0] c_base_q, c_depth_q;
	logic [30:0] c_step_q, f_step_q;
	logic [15:0] c_mix_q, f_fb_q, f_mix_q;
	logic [18:0] f_depth_q;

	// Control state.
	logic [31:0]               c_phase_q, f_phase_q;
	logic [cfc_pkg::CL_AW-1:0] c_wp_q;
	logic [cfc_pkg::FL_AW-1:0] f_wp_q;
	logic                      out_valid_q;

	// Payload registers.
	logic signed [23:0]        dry_q, s1_q, cout_q, out_q;
	logic signed [15:0]        sine_q;
	logic signed [47:0]        prod_q, acc_q;
	logic [cfc_pkg::CL_AW-1:0] p1_q;
	logic signed [8:0]         fr_q;
	logic signed [24:0]        diff_q;
	logic signed [25:0]        wet_q;

	logic signed [26:0] mul_a;
	logic signed [20:0] mul_b;
	logic [16:0]        cm, fm, fb;
	logic [31:0]        phase;
	logic signed [47:0] t15, interp, mix, fin_w;
	logic signed [22:0] dly, ip, fr, wp_ext, pos;
	logic signed [23:0] fin, rd;
	logic [23:0]        c_rdata, f_rdata;
	logic [cfc_pkg::CL_AW-1:0] c_addr;
	logic [cfc_pkg::FL_AW-1:0] f_addr;
	logic               c_we, f_we;

	assign cm = cfc_pkg::gain17(c_mix_q);
	assign fm = cfc_pkg::gain17(f_mix_q);
	assign fb = cfc_pkg::gain17(f_fb_q);
	assign phase = cmd.fx ? f_phase_q : c_phase_q;
	assign rd = cmd.fx ? f_rdata : c_rdata;
	assign sts.out_full = out_valid_q && !out_ready;
	assign out_sample = out_q;
	assign out_valid = out_valid_q;

	// Shared multiplier operand selection.
	always_comb begin
		case (cmd.op)
			cfc_pkg::OP_MDEP: begin
				mul_a = {{11{sine_q[15]}}, sine_q};
				mul_b = cmd.fx ? {2'b00, f_depth_q} : {1'b0, c_depth_q};
			end
			cfc_pkg::OP_MFR: begin
				mul_a = {{2{diff_q[24]}}, diff_q};
				mul_b = {{12{fr_q[8]}}, fr_q};
			end
			cfc_pkg::OP_C_MIXA: begin
				mul_a = {{3{dry_q[23]}}, dry_q};
				mul_b = {4'd0, 17'd32768 - cm};
			end
			cfc_pkg::OP_C_MIXB: begin
				mul_a = {wet_q[25], wet_q};
				mul_b = {4'd0, cm};
			end
			cfc_pkg::OP_F_FB: begin
				mul_a = {wet_q[25], wet_q};
				mul_b = {4'd0, fb};
			end
			cfc_pkg::OP_F_FIN: begin
				mul_a = {{3{cout_q[23]}}, cout_q};
				mul_b = {4'd0, 17'd32768 - fm};
			end
			cfc_pkg::OP_F_MIXB, cfc_pkg::OP_F_OUT: begin
				mul_a = {wet_q[25], wet_q};
				mul_b = {4'd0, fm};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Delay, tap position and fraction from the scaled sine, plus the interpolation, mix and feedback sums.
	always_comb begin
		t15 = prod_q / 48'sd32768;
		dly = (cmd.fx ? cfc_pkg::FLANGER_BASE_Q8 : $signed({3'b000, c_base_q})) + t15[22:0];
		ip = dly / 23'sd256;
		fr = dly % 23'sd256;
		wp_ext = cmd.fx ? $signed({12'd0, f_wp_q}) : $signed({11'd0, c_wp_q});
		pos = wp_ext - ip;
		interp = $signed({{24{s1_q[23]}}, s1_q}) + prod_q / 48'sd256;
		mix = (acc_q + prod_q) / 48'sd32768;
		fin_w = $signed({{24{cout_q[23]}}, cout_q}) + t15;
		fin = cfc_pkg::sat24(fin_w);
	end

	// Delay line addressing: clear, two tap reads, then the write.
	always_comb begin
		case (cmd.op)
			cfc_pkg::OP_CLEAR: begin
				c_addr = cmd.clr_addr;
				f_addr = cmd.clr_addr[cfc_pkg::FL_AW-1:0];
			end
			cfc_pkg::OP_RD1: begin
				c_addr = p1_q;
				f_addr = p1_q[cfc_pkg::FL_AW-1:0];
			end
			cfc_pkg::OP_RD2: begin
				c_addr = p1_q - 1'b1;
				f_addr = p1_q[cfc_pkg::FL_AW-1:0] - 1'b1;
			end
			default: begin
				c_addr = c_wp_q;
				f_addr = f_wp_q;
			end
		endcase
		c_we = (cmd.op == cfc_pkg::OP_CLEAR) || (cmd.op == cfc_pkg::OP_C_MIXC);
		f_we = (cmd.op == cfc_pkg::OP_CLEAR) || (cmd.op == cfc_pkg::OP_F_FIN);
	end

	cfc_ram #(.WIDTH(24), .DEPTH(cfc_pkg::CL_DEPTH)) u_c_line (
		.clk   (clk),
		.we    (c_we),
		.addr  (c_addr),
		.wdata ((cmd.op == cfc_pkg::OP_CLEAR) ? 24'd0 : dry_q),
		.rdata (c_rdata)
	);

	cfc_ram #(.WIDTH(24), .DEPTH(cfc_pkg::FL_DEPTH)) u_f_line (
		.clk   (clk),
		.we    (f_we),
		.addr  (f_addr),
		.wdata ((cmd.op == cfc_pkg::OP_CLEAR) ? 24'd0 : fin),
		.rdata (f_rdata)
	);

	// Configuration, LFO phases, write positions and output handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_base_q <= cfc_pkg::RST_C_BASE;
			c_depth_q <= cfc_pkg::RST_C_DEPTH;
			c_step_q <= cfc_pkg::RST_C_STEP;
			c_mix_q <= cfc_pkg::RST_C_MIX;
			f_depth_q <= cfc_pkg::RST_F_DEPTH;
			f_step_q <= cfc_pkg::RST_F_STEP;
			f_fb_q <= cfc_pkg::RST_F_FB;
			f_mix_q <= cfc_pkg::RST_F_MIX;
			c_phase_q <= '0;
			f_phase_q <= '0;
			c_wp_q <= '0;
			f_wp_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					cfc_pkg::REG_C_BASE:  c_base_q <= cfg_data[19:0];
					cfc_pkg::REG_C_DEPTH: c_depth_q <= cfg_data[19:0];
					cfc_pkg::REG_C_STEP:  c_step_q <= cfg_data[30:0];
					cfc_pkg::REG_C_MIX:   c_mix_q <= cfg_data[15:0];
					cfc_pkg::REG_F_DEPTH: f_depth_q <= cfg_data[18:0];
					cfc_pkg::REG_F_STEP:  f_step_q <= cfg_data[30:0];
					cfc_pkg::REG_F_FB:    f_fb_q <= cfg_data[15:0];
					cfc_pkg::REG_F_MIX:   f_mix_q <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (cmd.op == cfc_pkg::OP_PHASE) begin
				if (cmd.fx) f_phase_q <= f_phase_q + {1'b0, f_step_q};
				else c_phase_q <= c_phase_q + {1'b0, c_step_q};
			end
			if (cmd.op == cfc_pkg::OP_C_MIXC) c_wp_q <= c_wp_q + 1'b1;
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			if (cmd.op == cfc_pkg::OP_F_OUT && !sts.out_full) begin
				out_valid_q <= 1'b1;
				f_wp_q <= f_wp_q + 1'b1;
			end
		end
	end

	// Arithmetic pipeline registers.
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (cmd.load) dry_q <= dry_in;
		case (cmd.op)
			cfc_pkg::OP_SINE:   sine_q <= cfc_pkg::SINE_TAB[phase[31 -: cfc_pkg::SINE_AW]];
			cfc_pkg::OP_DELAY: begin
				p1_q <= pos[cfc_pkg::CL_AW-1:0];
				fr_q <= fr[8:0];
			end
			cfc_pkg::OP_RD2:    s1_q <= rd;
			cfc_pkg::OP_DIFF:   diff_q <= {rd[23], rd} - {s1_q[23], s1_q};
			cfc_pkg::OP_INTERP: wet_q <= interp[25:0];
			cfc_pkg::OP_C_MIXB, cfc_pkg::OP_F_MIXB: acc_q <= prod_q;
			cfc_pkg::OP_C_MIXC: cout_q <= cfc_pkg::sat24(mix);
			cfc_pkg::OP_F_OUT: begin
				if (!sts.out_full) out_q <= cfc_pkg::sat24(mix);
			end
			default: ;
		endcase
	end

	// A new sample is only taken while the sequencer is idle.
	ap_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> cmd.op == cfc_pkg::OP_IDLE)
		else $error("sample loaded outside idle");
	// A result appears only from the final mix step.
	ap_valid_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.op) == cfc_pkg::OP_F_OUT)
		else $error("result appeared without final mix");
	// The chorus write position moves once per sample, with the chorus write.
	ap_cwp: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(c_wp_q) |-> $past(cmd.op) == cfc_pkg::OP_C_MIXC)
		else $error("chorus write position moved outside its write");

endmodule

FILE: sv/chorus_flanger_chain_top.sv
// Top level of the mono chorus followed by a flanger with feedback.
// Depends on cfc_pkg, cfc_ram, cfc_ctrl and cfc_dp.
//
// Usage:
//  - s_* carries one dry sample per request (Q1.23), m_* one processed sample.
//  - cfg_* writes one of eight registers by index; cfg_ready is always high.
//    Write registers only while no sample is in flight.
//  - Each sample runs from acceptance to m_tvalid through a chorus pass of
//    12 sequencer steps and a flanger pass of 13 steps, the last of which is
//    the output step, using the shared multiplier and the single-port delay
//    line RAMs. A new sample is accepted in the cycle after the previous
//    result is registered, so samples never overlap in the chain.
//  - After reset both delay lines are cleared by a pass over the 4096 chorus
//    line addresses, one address per cycle; s_tready stays low for that time.
//    Register writes are taken during the pass.
//  - If m_tready is low, the finished result waits in the output register; the
//    next sample is still accepted and worked on, and its final step holds
//    until the output register is free.
module chorus_flanger_chain_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [23:0] dry_sample
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [23:0] out_sample
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	cfc_pkg::cmd_t cmd;
	cfc_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	cfc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	cfc_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.dry_in     (s_tdata),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.out_sample (m_tdata),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready)
	);

endmodule
